### hdl/abf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// abf_pkg
// Shared types, constants and AES helper functions for the Bloom filter insert
// block.
// ----------------------------------------------------------------------------
package abf_pkg;

  // width of a bit position / modulus (bit_count register)
  localparam int unsigned BW = 17;
  // width of a hash counter (holds up to 127)
  localparam int unsigned KW = 7;
  // width of a word number taken from a bit position
  localparam int unsigned IW = BW - 6;

  // configuration register indexes
  localparam logic [1:0] CFG_KEY_LOW   = 2'd0;
  localparam logic [1:0] CFG_KEY_HIGH  = 2'd1;
  localparam logic [1:0] CFG_HASH_CNT  = 2'd2;
  localparam logic [1:0] CFG_BIT_CNT   = 2'd3;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_WAIT,
    ST_RD_OUT,
    ST_AES,
    ST_ACC,
    ST_DIV,
    ST_DIV_STORE,
    ST_SET_RD,
    ST_SET_WR,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    DIV_H1,
    DIV_H2,
    DIV_C
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     aes_round;
    logic     aes_final;
    logic     acc_update;
    logic     div_start;
    div_sel_t div_sel;
    logic     div_step;
    logic     div_store;
    logic     set_rd;
    logic     set_wr;
    logic     clr_wr;
    logic     out_load;
    logic     out_from_ram;
  } cmd_t;

  typedef struct packed {
    logic          clr_last;
    logic          is_last;
    logic [KW-1:0] k;
  } status_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes, ShiftRows and (except in the last round) MixColumns
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3, all;
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i + 4*c] = SBOX[s[8*(i + 4*((c + i) & 3)) +: 8]];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c];
        a1 = t[4*c+1];
        a2 = t[4*c+2];
        a3 = t[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int j = 0; j < 16; j++) begin
      o[8*j +: 8] = t[j];
    end
    return o;
  endfunction

  // next AES-128 round key
  function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rcon);
    logic [31:0] t, w0, w1, w2, w3;
    t  = {SBOX[rk[103:96]], SBOX[rk[127:120]], SBOX[rk[119:112]],
          SBOX[rk[111:104]] ^ rcon};
    w0 = rk[31:0] ^ t;
    w1 = rk[63:32] ^ w0;
    w2 = rk[95:64] ^ w1;
    w3 = rk[127:96] ^ w2;
    return {w3, w2, w1, w0};
  endfunction

endpackage
`default_nettype wire

### hdl/abf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// abf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module abf_ram #(
  parameter int W = 64,
  parameter int D = 1024,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output      logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hdl/abf_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// abf_dp
// Datapath: config registers, iterative AES-128, accumulator, bit-serial
// modulo unit, residue stepping, filter RAM and result register.
// ----------------------------------------------------------------------------
module abf_dp #(
  parameter int FILTER_WORDS = 1024,
  parameter int MAX_HASHES   = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [63:0]          cfg_data,
  input  wire logic                 in_op,
  input  wire logic                 in_last,
  input  wire logic [63:0]          in_block_low,
  input  wire logic [63:0]          in_block_high,
  input  wire logic [9:0]           in_word_index,
  input  wire abf_pkg::cmd_t        cmd,
  output      abf_pkg::status_t     status,
  output      logic [63:0]          out_word_data,
  output      logic                 out_inserted
);

  localparam int AW = (FILTER_WORDS > 1) ? $clog2(FILTER_WORDS) : 1;
  localparam int BW = abf_pkg::BW;
  localparam int KW = abf_pkg::KW;
  localparam int IW = abf_pkg::IW;
  localparam logic [31:0] LIMIT = 32'(FILTER_WORDS) * 32'd64;

  // configuration
  logic [63:0]   key_lo_r, key_hi_r;
  logic [5:0]    hcnt_r;
  logic [BW-1:0] bcnt_r;

  // AES and accumulator
  logic [127:0] s_r, rk_r, rk_n;
  logic [7:0]   rcon_r;
  logic [63:0]  acc_r, acc_n;
  logic         last_r, op_r;
  logic [9:0]   widx_r;

  // hashing
  logic [31:0]   h1_r, h2_r, h_r, div_x_r;
  logic [BW-1:0] rem_r, r_r, a_r, c_r;
  logic [BW-1:0] m, rem_n, c_n, r_n;
  logic [KW-1:0] k;
  logic [BW:0]   shifted, diff, rem1;
  logic [32:0]   hsum;
  logic signed [BW+1:0] sres;

  // filter RAM
  logic [AW-1:0]    clr_addr_r;
  logic [AW+IW-1:0] bit_word_w;
  logic [AW+9:0]    rd_word_w;
  logic [AW-1:0]    bit_addr, raddr, waddr;
  logic             we, rd_ok;
  logic [63:0]      rdata, wdata;

  logic [63:0] out_data_r;
  logic        out_ins_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r <= '0;
      key_hi_r <= '0;
      hcnt_r   <= 6'd1;
      bcnt_r   <= 17'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        abf_pkg::CFG_KEY_LOW:  key_lo_r <= cfg_data;
        abf_pkg::CFG_KEY_HIGH: key_hi_r <= cfg_data;
        abf_pkg::CFG_HASH_CNT: hcnt_r   <= cfg_data[5:0];
        abf_pkg::CFG_BIT_CNT:  bcnt_r   <= cfg_data[BW-1:0];
        default: ;
      endcase
    end
  end

  // effective modulus and hash count
  always_comb begin
    if (bcnt_r < BW'(8)) begin
      m = BW'(8);
    end else if (32'(bcnt_r) > LIMIT) begin
      m = LIMIT[BW-1:0];
    end else begin
      m = bcnt_r;
    end
    k = (KW'(hcnt_r) > KW'(MAX_HASHES)) ? KW'(MAX_HASHES) : KW'(hcnt_r);
  end

  assign rk_n  = abf_pkg::key_next(rk_r, rcon_r);
  assign acc_n = acc_r ^ s_r[63:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.acc_update) begin
      acc_r <= last_r ? 64'd0 : acc_n;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_r    <= {in_block_high, in_block_low} ^ {key_hi_r, key_lo_r};
      rk_r   <= {key_hi_r, key_lo_r};
      rcon_r <= 8'h01;
      last_r <= in_last;
      op_r   <= in_op;
      widx_r <= in_word_index;
    end else if (cmd.aes_round) begin
      s_r    <= abf_pkg::aes_round(s_r, cmd.aes_final) ^ rk_n;
      rk_r   <= rk_n;
      rcon_r <= abf_pkg::xtime(rcon_r);
    end
    if (cmd.acc_update) begin
      h1_r <= acc_n[31:0];
      h2_r <= key_lo_r[31:0] ^ acc_n[31:0];
    end
  end

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    shifted = {rem_r, div_x_r[31]};
    diff    = shifted - {1'b0, m};
    rem_n   = (shifted >= {1'b0, m}) ? diff[BW-1:0] : shifted[BW-1:0];
    rem1    = {1'b0, rem_r} + (BW+1)'(1);
    c_n     = (rem1 == {1'b0, m}) ? '0 : rem1[BW-1:0];
  end

  // next residue: (r + (h2 mod m) - carry * (2^32 mod m)) mod m
  always_comb begin
    hsum = {1'b0, h_r} + {1'b0, h2_r};
    sres = $signed({2'b00, r_r}) + $signed({2'b00, a_r})
         - (hsum[32] ? $signed({2'b00, c_r}) : $signed((BW+2)'(0)));
    if (sres < 0) begin
      sres = sres + $signed({2'b00, m});
    end else if (sres >= $signed({2'b00, m})) begin
      sres = sres - $signed({2'b00, m});
    end
    r_n = sres[BW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= '0;
      // first start comes with the accumulator update, so h1 is taken before
      // its register; a start beside a store loads the dividend that follows
      unique case (cmd.div_sel)
        abf_pkg::DIV_H1: div_x_r <= cmd.div_store ? h2_r : acc_n[31:0];
        default:         div_x_r <= 32'hffff_ffff;
      endcase
    end else if (cmd.div_step) begin
      rem_r   <= rem_n;
      div_x_r <= {div_x_r[30:0], 1'b0};
    end
    if (cmd.div_store) begin
      unique case (cmd.div_sel)
        abf_pkg::DIV_H1: begin
          r_r <= rem_r;
          h_r <= h1_r;
        end
        abf_pkg::DIV_H2: a_r <= rem_r;
        abf_pkg::DIV_C:  c_r <= c_n;
        default: ;
      endcase
    end else if (cmd.set_wr) begin
      r_r <= r_n;
      h_r <= hsum[31:0];
    end
  end

  // filter RAM addressing
  assign bit_word_w = {AW'(0), r_r[BW-1:6]};
  assign bit_addr   = bit_word_w[AW-1:0];
  assign rd_word_w  = {AW'(0), widx_r};
  assign rd_ok      = 32'(widx_r) < 32'(FILTER_WORDS);
  assign raddr      = cmd.set_rd ? bit_addr : rd_word_w[AW-1:0];
  assign we         = cmd.clr_wr | cmd.set_wr;
  assign waddr      = cmd.clr_wr ? clr_addr_r : bit_addr;
  assign wdata      = cmd.clr_wr ? 64'd0 : (rdata | (64'd1 << r_r[5:0]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  abf_ram #(.W(64), .D(FILTER_WORDS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= (cmd.out_from_ram && rd_ok) ? rdata : 64'd0;
      out_ins_r  <= !cmd.out_from_ram && !op_r && last_r;
    end
  end

  assign status.clr_last = {1'b0, clr_addr_r} == (AW+1)'(FILTER_WORDS - 1);
  assign status.is_last  = last_r;
  assign status.k        = k;

  assign out_word_data = out_data_r;
  assign out_inserted  = out_ins_r;

endmodule
`default_nettype wire

### hdl/abf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// abf_ctrl
// Controller: sequences clearing, AES rounds, the three reductions, the
// per-hash read-modify-write and the result handoff.
// ----------------------------------------------------------------------------
module abf_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  input  wire logic             in_op,
  output      logic             in_tready,
  output      logic             out_tvalid,
  input  wire logic             out_tready,
  input  wire abf_pkg::status_t status,
  output      abf_pkg::cmd_t    cmd
);

  abf_pkg::state_t   state_r, state_nxt;
  abf_pkg::div_sel_t sel_r, sel_nxt;
  logic [3:0] round_r, round_nxt;
  logic [4:0] bit_r, bit_nxt;
  logic [abf_pkg::KW-1:0] hash_r, hash_nxt;
  logic out_valid_r, out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= abf_pkg::ST_CLEAR;
      sel_r       <= abf_pkg::DIV_H1;
      round_r     <= '0;
      bit_r       <= '0;
      hash_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      round_r <= round_nxt;
      bit_r   <= bit_nxt;
      hash_r  <= hash_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    round_nxt = round_r;
    bit_nxt   = bit_r;
    hash_nxt  = hash_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.div_sel = sel_r;
    unique case (state_r)
      abf_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) begin
          state_nxt = abf_pkg::ST_IDLE;
        end
      end
      abf_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          round_nxt = '0;
          state_nxt = (in_op == abf_pkg::OP_READ) ? abf_pkg::ST_RD_WAIT : abf_pkg::ST_AES;
        end
      end
      abf_pkg::ST_RD_WAIT: state_nxt = abf_pkg::ST_RD_OUT;
      abf_pkg::ST_RD_OUT: begin
        // read data stays valid while the word address is held
        if (out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_from_ram = 1'b1;
          state_nxt        = abf_pkg::ST_IDLE;
        end
      end
      abf_pkg::ST_AES: begin
        cmd.aes_round = 1'b1;
        cmd.aes_final = (round_r == 4'd9);
        round_nxt     = round_r + 4'd1;
        if (round_r == 4'd9) begin
          state_nxt = abf_pkg::ST_ACC;
        end
      end
      abf_pkg::ST_ACC: begin
        cmd.acc_update = 1'b1;
        if (status.is_last) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = abf_pkg::DIV_H1;
          sel_nxt       = abf_pkg::DIV_H1;
          bit_nxt       = '0;
          state_nxt     = abf_pkg::ST_DIV;
        end else begin
          state_nxt = abf_pkg::ST_FINISH;
        end
      end
      abf_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        bit_nxt      = bit_r + 5'd1;
        if (bit_r == 5'd31) begin
          state_nxt = abf_pkg::ST_DIV_STORE;
        end
      end
      abf_pkg::ST_DIV_STORE: begin
        // div_sel names the remainder being stored
        cmd.div_store = 1'b1;
        bit_nxt       = '0;
        hash_nxt      = '0;
        unique case (sel_r)
          abf_pkg::DIV_H1: begin
            cmd.div_start = 1'b1;
            sel_nxt       = abf_pkg::DIV_H2;
            state_nxt     = abf_pkg::ST_DIV;
          end
          abf_pkg::DIV_H2: begin
            cmd.div_start = 1'b1;
            sel_nxt       = abf_pkg::DIV_C;
            state_nxt     = abf_pkg::ST_DIV;
          end
          default: begin
            state_nxt = (status.k == '0) ? abf_pkg::ST_FINISH : abf_pkg::ST_SET_RD;
          end
        endcase
      end
      abf_pkg::ST_SET_RD: begin
        cmd.set_rd = 1'b1;
        state_nxt  = abf_pkg::ST_SET_WR;
      end
      abf_pkg::ST_SET_WR: begin
        cmd.set_wr = 1'b1;
        hash_nxt   = hash_r + abf_pkg::KW'(1);
        state_nxt  = (hash_nxt == status.k) ? abf_pkg::ST_FINISH : abf_pkg::ST_SET_RD;
      end
      abf_pkg::ST_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = abf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = abf_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### hdl/aes_hashed_bloom_filter_insert.sv
`default_nettype none
// Path from input transfer to out_tvalid: a read goes through ST_RD_WAIT and
//   ST_RD_OUT; a non-final absorb through the AES rounds, ST_ACC and ST_FINISH;
//   a final block also through the 32-step remainder unit run for h1, h2 and
//   2^32 and one RAM read-modify-write per hash.
// Items are taken one at a time: the next transfer is taken in the cycle after
//   the result is loaded; the result register lets the next item start while a
//   result waits. After reset a clearing pass zeroes every filter word.
// ----------------------------------------------------------------------------
// aes_hashed_bloom_filter_insert
// Bloom filter insert with AES-128 based double hashing, plus word readback.
// ----------------------------------------------------------------------------
module aes_hashed_bloom_filter_insert #(
  parameter int FILTER_WORDS = 1024,
  parameter int MAX_HASHES   = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_valid,
  output      logic         cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [63:0]  cfg_data,
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  // block_low[63:0], block_high[127:64], word_index[137:128], zero pad
  input  wire logic [143:0] in_tdata,
  // operation
  input  wire logic         in_tuser,
  input  wire logic         in_tlast,
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  // word_data[63:0]
  output      logic [63:0]  out_tdata,
  // inserted
  output      logic         out_tuser
);

  abf_pkg::cmd_t    cmd;
  abf_pkg::status_t status;

  assign cfg_ready = 1'b1;

  abf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_op      (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  abf_dp #(
    .FILTER_WORDS (FILTER_WORDS),
    .MAX_HASHES   (MAX_HASHES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_op         (in_tuser),
    .in_last       (in_tlast),
    .in_block_low  (in_tdata[63:0]),
    .in_block_high (in_tdata[127:64]),
    .in_word_index (in_tdata[137:128]),
    .cmd           (cmd),
    .status        (status),
    .out_word_data (out_tdata),
    .out_inserted  (out_tuser)
  );

endmodule
`default_nettype wire

### sim/aes_hashed_bloom_filter_insert_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aes_hashed_bloom_filter_insert_tb
// Streams element blocks and word reads into the Bloom filter insert block
// under several key, hash count and bit count settings, predicts every result
// with its own AES-128 and double-hashing model, built on the package S-box,
// and checks each transfer on the result channel against it.
// ----------------------------------------------------------------------------
module aes_hashed_bloom_filter_insert_tb;

  localparam int NWORDS = 1024;
  localparam int NHASH  = 32;

  typedef struct {
    logic        op;
    logic [63:0] lo;
    logic [63:0] hi;
    logic        last;
    logic [9:0]  widx;
  } blk_item_t;

  typedef struct {
    logic [63:0] word;
    logic        ins;
  } filt_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = abf_pkg::CFG_KEY_LOW;
  logic [63:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [143:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic out_tuser;

  aes_hashed_bloom_filter_insert u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow state of the filter
  logic [63:0]  shadow_words [NWORDS];
  logic [127:0] acc_q;
  logic [127:0] key_q;
  logic [5:0]   hash_cfg;
  logic [16:0]  bits_cfg;

  blk_item_t    pending_blocks [$];
  filt_result_t expected_words [$];
  int errors = 0, n_in = 0, n_out = 0, n_ins = 0, n_rd = 0;
  bit quiet = 1'b0;

  function automatic logic [7:0] gmul2(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] cipher_block(input logic [127:0] key,
                                                input logic [127:0] pt);
    logic [7:0] rk [176];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] tmp [4];
    logic [7:0] rcon, first, a0, a1, a2, a3, all;
    logic [127:0] ct;
    rcon = 8'h01;
    for (int i = 0; i < 16; i++) rk[i] = key[8*i +: 8];
    for (int i = 16; i < 176; i += 4) begin
      for (int c = 0; c < 4; c++) tmp[c] = rk[i-4+c];
      if ((i & 15) == 0) begin
        first  = tmp[0];
        tmp[0] = abf_pkg::SBOX[tmp[1]] ^ rcon;
        tmp[1] = abf_pkg::SBOX[tmp[2]];
        tmp[2] = abf_pkg::SBOX[tmp[3]];
        tmp[3] = abf_pkg::SBOX[first];
        rcon   = gmul2(rcon);
      end
      for (int c = 0; c < 4; c++) rk[i+c] = rk[i-16+c] ^ tmp[c];
    end
    for (int i = 0; i < 16; i++) s[i] = pt[8*i +: 8] ^ rk[i];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[i+4*c] = abf_pkg::SBOX[s[i + 4*((c+i) & 3)]];
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ all ^ gmul2(a0 ^ a1);
          t[4*c+1] = a1 ^ all ^ gmul2(a1 ^ a2);
          t[4*c+2] = a2 ^ all ^ gmul2(a2 ^ a3);
          t[4*c+3] = a3 ^ all ^ gmul2(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*r+i];
    end
    for (int i = 0; i < 16; i++) ct[8*i +: 8] = s[i];
    return ct;
  endfunction

  // one accepted item: update shadow state, queue its result
  task automatic absorb_or_read(input blk_item_t it);
    filt_result_t r;
    logic [31:0] h1, h2, h;
    int unsigned m, k, idx;
    r.word = '0;
    r.ins  = 1'b0;
    if (it.op == abf_pkg::OP_READ) begin
      r.word = shadow_words[it.widx];
      n_rd++;
    end else begin
      acc_q ^= cipher_block(key_q, {it.hi, it.lo});
      if (it.last) begin
        h1 = acc_q[31:0];
        h2 = key_q[31:0] ^ acc_q[31:0];
        m  = bits_cfg < 8 ? 8 : (bits_cfg > NWORDS*64 ? NWORDS*64 : bits_cfg);
        k  = hash_cfg > NHASH ? NHASH : hash_cfg;
        for (int unsigned i = 0; i < k; i++) begin
          h = h1 + i * h2;
          idx = h % m;
          shadow_words[idx >> 6][idx & 63] = 1'b1;
        end
        acc_q = '0;
        r.ins = 1'b1;
        n_ins++;
      end
    end
    expected_words.push_back(r);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        absorb_or_read(pending_blocks.pop_front());
        n_in++;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (pending_blocks.size() > 0 && (quiet || $urandom_range(99) >= 17)) begin
          in_tvalid <= 1'b1;
          in_tuser  <= pending_blocks[0].op;
          in_tlast  <= pending_blocks[0].last;
          in_tdata  <= {6'd0, pending_blocks[0].widx, pending_blocks[0].hi,
                        pending_blocks[0].lo};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  int hold_cnt = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    filt_result_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_out++;
        if (expected_words.size() == 0) begin
          $error("result transfer with nothing expected: word %h inserted %b",
                 out_tdata, out_tuser);
          errors++;
        end else begin
          e = expected_words.pop_front();
          if (out_tdata !== e.word) begin
            $error("word_data: expected %h actual %h", e.word, out_tdata);
            errors++;
          end
          if (out_tuser !== e.ins) begin
            $error("inserted: expected %b actual %b", e.ins, out_tuser);
            errors++;
          end
        end
      end
      // long hold-off so the block backs up and stalls its input
      if (!hold_done && n_out == 400) begin
        hold_done <= 1'b1;
        hold_cnt  <= 600;
        out_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt  <= hold_cnt - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= quiet || $urandom_range(99) >= 17;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic push_item(input logic op, input logic [63:0] lo, input logic [63:0] hi,
                           input logic last, input logic [9:0] widx);
    blk_item_t it;
    it.op = op; it.lo = lo; it.hi = hi; it.last = last; it.widx = widx;
    pending_blocks.push_back(it);
  endtask

  // element of nblk blocks, reads sprinkled in between
  task automatic push_element(input int nblk);
    for (int b = 0; b < nblk; b++) begin
      if ($urandom_range(9) == 0) begin
        push_item(abf_pkg::OP_READ, rand64(), rand64(), 1'($urandom), 10'($urandom));
      end
      push_item(abf_pkg::OP_ABSORB, rand64(), rand64(), b == nblk - 1, 10'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (pending_blocks.size() > 0 || expected_words.size() > 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      abf_pkg::CFG_KEY_LOW:  key_q[63:0]   = val;
      abf_pkg::CFG_KEY_HIGH: key_q[127:64] = val;
      abf_pkg::CFG_HASH_CNT: hash_cfg      = val[5:0];
      abf_pkg::CFG_BIT_CNT:  bits_cfg      = val[16:0];
      default: ;
    endcase
  endtask

  // random phase; part of the reads aimed at the words in use
  task automatic run_phase(input int n_items);
    int start;
    int span;
    start = n_in + pending_blocks.size();
    span  = (bits_cfg < 64 ? 1 : (bits_cfg > 65536 ? 1024 : (bits_cfg + 63) / 64));
    while (n_in + pending_blocks.size() - start < n_items) begin
      case ($urandom_range(9))
        0: push_item(abf_pkg::OP_READ, rand64(), rand64(), 1'($urandom),
                     10'($urandom_range(span - 1)));
        1: push_item(abf_pkg::OP_READ, rand64(), rand64(), 1'($urandom), 10'($urandom));
        2: push_item(abf_pkg::OP_ABSORB, rand64(), rand64(), 1'($urandom), 10'($urandom));
        default: push_element($urandom_range(1, 4));
      endcase
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < NWORDS; i++) shadow_words[i] = '0;
    acc_q = '0; key_q = '0; hash_cfg = 6'd1; bits_cfg = 17'd65536;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, extreme blocks and words, read inside an element
    push_item(abf_pkg::OP_READ, '0, '0, 1'b0, 10'd0);
    push_item(abf_pkg::OP_READ, '1, '1, 1'b1, 10'd1023);
    push_item(abf_pkg::OP_ABSORB, '0, '0, 1'b1, 10'd0);
    push_item(abf_pkg::OP_ABSORB, '1, '1, 1'b1, 10'h3ff);
    push_item(abf_pkg::OP_ABSORB, 64'h0123456789abcdef, '0, 1'b0, 10'd0);
    push_item(abf_pkg::OP_READ, '0, '0, 1'b1, 10'd512);
    push_item(abf_pkg::OP_ABSORB, '1, 64'h00000000000000ff, 1'b1, 10'd0);
    for (int i = 0; i < 8; i++) push_item(abf_pkg::OP_READ, '0, '0, 1'b0, 10'(i * 146));
    push_item(abf_pkg::OP_READ, '0, '0, 1'b0, 10'h3ff);
    wait_drained();

    write_reg(abf_pkg::CFG_KEY_LOW, 64'h2b7e151628aed2a6);
    write_reg(abf_pkg::CFG_KEY_HIGH, 64'habf7158809cf4f3c);
    write_reg(abf_pkg::CFG_HASH_CNT, 64'd32);
    write_reg(abf_pkg::CFG_BIT_CNT, 64'd8);
    push_item(abf_pkg::OP_ABSORB, '0, '0, 1'b1, 10'd0);
    push_item(abf_pkg::OP_READ, '0, '0, 1'b0, 10'd0);
    run_phase(150);

    // out-of-range settings: no hashes, oversize bit count, junk upper bits
    write_reg(abf_pkg::CFG_HASH_CNT, 64'hffffffffffffffc0);
    write_reg(abf_pkg::CFG_BIT_CNT, 64'hffffffffffffffff);
    run_phase(80);
    write_reg(abf_pkg::CFG_HASH_CNT, 64'd63);
    write_reg(abf_pkg::CFG_BIT_CNT, 64'd7);
    run_phase(100);
    write_reg(abf_pkg::CFG_KEY_LOW, '1);
    write_reg(abf_pkg::CFG_KEY_HIGH, '1);
    write_reg(abf_pkg::CFG_BIT_CNT, 64'd131071);
    run_phase(150);

    quiet = 1'b1;
    write_reg(abf_pkg::CFG_KEY_LOW, rand64());
    write_reg(abf_pkg::CFG_KEY_HIGH, rand64());
    write_reg(abf_pkg::CFG_HASH_CNT, 64'd1);
    write_reg(abf_pkg::CFG_BIT_CNT, 64'd65536);
    run_phase(150);
    quiet = 1'b0;

    for (int p = 0; p < 4; p++) begin
      write_reg(abf_pkg::CFG_KEY_LOW, rand64());
      write_reg(abf_pkg::CFG_KEY_HIGH, rand64());
      write_reg(abf_pkg::CFG_HASH_CNT, 64'($urandom_range(1, 32)));
      write_reg(abf_pkg::CFG_BIT_CNT, 64'($urandom_range(8, 4096)));
      run_phase(150);
    end

    $display("covered %0d input items (%0d reads, %0d insertions), %0d results",
             n_in, n_rd, n_ins, n_out);
    $display("settings: zero/all-ones/random keys, hash counts 0..63, bit counts 7..131071");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #32000000;
    $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
